// ===== rtl/w16a_pkg.sv =====
// package for the 16-bit alu execute block
// types, opcode codes and pipeline constants; no dependencies
`timescale 1ns / 1ps

package w16a_pkg;

  localparam int WordW   = 16;
  localparam int OpW     = 5;
  localparam int DivDepth = 8;

  localparam logic [OpW-1:0] OP_SET = 5'h01;
  localparam logic [OpW-1:0] OP_ADD = 5'h02;
  localparam logic [OpW-1:0] OP_SUB = 5'h03;
  localparam logic [OpW-1:0] OP_MUL = 5'h04;
  localparam logic [OpW-1:0] OP_MLI = 5'h05;
  localparam logic [OpW-1:0] OP_DIV = 5'h06;
  localparam logic [OpW-1:0] OP_DVI = 5'h07;
  localparam logic [OpW-1:0] OP_MOD = 5'h08;
  localparam logic [OpW-1:0] OP_MDI = 5'h09;
  localparam logic [OpW-1:0] OP_AND = 5'h0a;
  localparam logic [OpW-1:0] OP_BOR = 5'h0b;
  localparam logic [OpW-1:0] OP_XOR = 5'h0c;
  localparam logic [OpW-1:0] OP_SHR = 5'h0d;
  localparam logic [OpW-1:0] OP_ASR = 5'h0e;
  localparam logic [OpW-1:0] OP_SHL = 5'h0f;
  localparam logic [OpW-1:0] OP_IFB = 5'h10;
  localparam logic [OpW-1:0] OP_IFC = 5'h11;
  localparam logic [OpW-1:0] OP_IFE = 5'h12;
  localparam logic [OpW-1:0] OP_IFN = 5'h13;
  localparam logic [OpW-1:0] OP_IFG = 5'h14;
  localparam logic [OpW-1:0] OP_IFA = 5'h15;
  localparam logic [OpW-1:0] OP_IFL = 5'h16;
  localparam logic [OpW-1:0] OP_IFU = 5'h17;
  localparam logic [OpW-1:0] OP_ADX = 5'h1a;
  localparam logic [OpW-1:0] OP_SBX = 5'h1b;
  localparam logic [OpW-1:0] OP_STI = 5'h1e;
  localparam logic [OpW-1:0] OP_STD = 5'h1f;

  localparam logic [1:0] STEP_NONE = 2'd0;
  localparam logic [1:0] STEP_INC  = 2'd1;
  localparam logic [1:0] STEP_DEC  = 2'd2;

  typedef enum logic [2:0] {
    DK_NONE,
    DK_UDIV,
    DK_SDIV,
    DK_UMOD,
    DK_SMOD
  } dkind_t;

  typedef struct packed {
    logic [OpW-1:0]   operation;
    logic [WordW-1:0] operand_b;
    logic [WordW-1:0] operand_a;
    logic [WordW-1:0] overflow_in;
  } item_t;

  typedef struct packed {
    logic   valid;
    dkind_t kind;
    item_t  item;
  } head_t;

  typedef struct packed {
    logic [WordW-1:0] result_b;
    logic [WordW-1:0] overflow_out;
    logic             skip_next;
    logic             b_written;
    logic [1:0]       index_step;
  } res_t;

  typedef struct packed {
    res_t   res;
    dkind_t kind;
    logic   neg_q;
    logic   neg_r;
    logic   dz;
  } stage_t;

endpackage

// ===== rtl/word16_alu_with_overflow_word.sv =====
// top level of the 16-bit alu execute block with overflow word
// holds w16a_front (queue) and w16a_back (execute and divider pipeline); uses w16a_pkg
//
// channel | dir | fields
// in_     | in  | operation, operand_b, operand_a, overflow_in
// out_    | out | result_b, overflow_out, skip_next, b_written, index_step
//
// one item per cycle sustained while the output is not stalled; an accepted item goes
// through the queue, then the eight divider pipeline stages that every item passes, then the output register
// reset clears the queue and the pipeline valid bits
// a stalled output holds the whole back pipeline; the queue keeps taking items until full
`timescale 1ns / 1ps

module word16_alu_with_overflow_word (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // operation, operand_b, operand_a, overflow_in, zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // result_b, overflow_out, skip_next, b_written,
                                  // index_step, zero pad
);
  import w16a_pkg::*;

  item_t in_item;
  head_t head;
  res_t  res;
  logic  full, pop;

  assign in_item.operation   = in_tdata[4:0];
  assign in_item.operand_b   = in_tdata[20:5];
  assign in_item.operand_a   = in_tdata[36:21];
  assign in_item.overflow_in = in_tdata[52:37];
  assign in_tready = !full;

  w16a_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_tvalid),
    .push_item(in_item),
    .full     (full),
    .pop      (pop),
    .head     (head)
  );

  w16a_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .pop      (pop),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (res)
  );

  assign out_tdata = {4'd0, res.index_step, res.b_written, res.skip_next,
                      res.overflow_out, res.result_b};

  a_skip_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(res.skip_next && res.b_written))
    else $error("test result also writes b");

  a_step_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res.index_step != 2'd3))
    else $error("bad index step");

  a_step_writes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res.index_step != STEP_NONE) |-> res.b_written)
    else $error("index step without write");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid && head.valid) |-> pop)
    else $error("back stalled with empty output");

endmodule

// ===== rtl/w16a_front.sv =====
// front part: two-entry item queue that tags each item with its divider class
// depends on w16a_pkg
`timescale 1ns / 1ps

module w16a_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  w16a_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output w16a_pkg::head_t head
);
  import w16a_pkg::*;

  dkind_t kind_sel;
  dkind_t kind_r [2];
  item_t  item_r [2];
  logic   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic   do_push, do_pop;

  always_comb begin
    unique case (push_item.operation)
      OP_DIV:  kind_sel = DK_UDIV;
      OP_DVI:  kind_sel = DK_SDIV;
      OP_MOD:  kind_sel = DK_UMOD;
      OP_MDI:  kind_sel = DK_SMOD;
      default: kind_sel = DK_NONE;
    endcase
  end

  assign full    = (cnt_r == 2'd2);
  assign do_push = push && !full;
  assign do_pop  = pop && (cnt_r != 2'd0);
  assign wp_nxt  = wp_r ^ do_push;
  assign rp_nxt  = rp_r ^ do_pop;
  assign cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      item_r[wp_r] <= push_item;
      kind_r[wp_r] <= kind_sel;
    end
  end

  assign head.valid = (cnt_r != 2'd0);
  assign head.kind  = kind_r[rp_r];
  assign head.item  = item_r[rp_r];

endmodule

// ===== rtl/w16a_div.sv =====
// pipelined restoring divider: 16-bit numerator shifted up by 16 over a 16-bit divisor
// four quotient bits per stage; also gives numerator mod divisor; depends on w16a_pkg
`timescale 1ns / 1ps

module w16a_div (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] num_in,
  input  logic [15:0] den_in,
  output logic [31:0] quo_out,
  output logic [15:0] mod_out
);
  import w16a_pkg::*;

  localparam int ModStage = DivDepth / 2 - 1;

  logic [15:0] num_r [DivDepth];
  logic [15:0] den_r [DivDepth];
  logic [15:0] rem_r [DivDepth];
  logic [31:0] quo_r [DivDepth];
  logic [15:0] mod_r [DivDepth];

  logic [15:0] p_num [DivDepth];
  logic [15:0] p_den [DivDepth];
  logic [15:0] p_rem [DivDepth];
  logic [31:0] p_quo [DivDepth];
  logic [15:0] p_mod [DivDepth];
  logic [19:0] st    [DivDepth];

  function automatic logic [19:0] div4(input logic [15:0] rem, input logic [3:0] bits,
                                       input logic [15:0] den);
    logic [16:0] r;
    logic [15:0] rr;
    logic [3:0]  q;
    rr = rem;
    q  = 4'd0;
    for (int k = 0; k < 4; k++) begin
      r = {rr, bits[3-k]};
      if (r >= {1'b0, den}) begin
        r      = r - {1'b0, den};
        q[3-k] = 1'b1;
      end
      rr = r[15:0];
    end
    return {rr, q};
  endfunction

  always_comb begin
    for (int i = 0; i < DivDepth; i++) begin
      if (i == 0) begin
        p_num[i] = num_in;
        p_den[i] = den_in;
        p_rem[i] = 16'd0;
        p_quo[i] = 32'd0;
        p_mod[i] = 16'd0;
      end else begin
        p_num[i] = num_r[i-1];
        p_den[i] = den_r[i-1];
        p_rem[i] = rem_r[i-1];
        p_quo[i] = quo_r[i-1];
        p_mod[i] = mod_r[i-1];
      end
      st[i] = div4(p_rem[i], p_num[i][15:12], p_den[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < DivDepth; i++) begin
        num_r[i] <= {p_num[i][11:0], 4'd0};
        den_r[i] <= p_den[i];
        rem_r[i] <= st[i][19:4];
        quo_r[i] <= {p_quo[i][27:0], st[i][3:0]};
        mod_r[i] <= (i == ModStage) ? st[i][19:4] : p_mod[i];
      end
    end
  end

  assign quo_out = quo_r[DivDepth-1];
  assign mod_out = mod_r[DivDepth-1];

endmodule

// ===== rtl/w16a_back.sv =====
// back part: executes the queue head, runs divides through the divider pipeline
// and holds the result item in an output register; depends on w16a_pkg, w16a_div
`timescale 1ns / 1ps

module w16a_back (
  input  logic             clk,
  input  logic             rst_n,
  input  w16a_pkg::head_t  head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output w16a_pkg::res_t   out_res
);
  import w16a_pkg::*;

  logic   adv;
  stage_t s0;
  stage_t pl_r [DivDepth];
  logic   vld_r [DivDepth];
  logic   ov_r;
  res_t   res_r, res_nxt;
  logic [15:0] b, a, ex, num, den;
  logic [16:0] add_t;
  logic [17:0] adx_t, sbx_v;
  logic [31:0] mul_u, mul_s, shr_t, shl_t, asr_t;
  logic [31:0] quo, quo_n;
  logic [15:0] md, qhi;
  logic [3:0]  asr_sh;

  assign b  = head.item.operand_b;
  assign a  = head.item.operand_a;
  assign ex = head.item.overflow_in;

  assign adv = !ov_r || out_ready;
  assign pop = adv && head.valid;

  assign add_t  = {1'b0, b} + {1'b0, a};
  assign adx_t  = {2'b0, b} + {2'b0, a} + {2'b0, ex};
  assign sbx_v  = {2'b0, b} - {2'b0, a} + {2'b0, ex};
  assign mul_u  = {16'd0, b} * {16'd0, a};
  assign mul_s  = 32'($signed(b)) * 32'($signed(a));
  assign shr_t  = {b, 16'd0} >> a[4:0];
  assign shl_t  = {16'd0, b} << a[4:0];
  assign asr_sh = (a[4:0] > 5'd15) ? 4'd15 : a[3:0];
  assign asr_t  = {b, 16'd0} >> a[4:0];

  always_comb begin
    s0.res.result_b     = b;
    s0.res.overflow_out = ex;
    s0.res.skip_next    = 1'b0;
    s0.res.b_written    = 1'b0;
    s0.res.index_step   = STEP_NONE;
    s0.kind  = head.kind;
    s0.dz    = (a == 16'd0);
    s0.neg_q = 1'b0;
    s0.neg_r = 1'b0;
    num = b;
    den = a;
    if (head.kind == DK_SDIV || head.kind == DK_SMOD) begin
      num      = b[15] ? 16'(-b) : b;
      den      = a[15] ? 16'(-a) : a;
      s0.neg_q = b[15] ^ a[15];
      s0.neg_r = b[15];
    end
    unique case (head.item.operation)
      OP_SET: begin s0.res.result_b = a; s0.res.b_written = 1'b1; end
      OP_ADD: begin
        s0.res.result_b = add_t[15:0]; s0.res.overflow_out = {15'd0, add_t[16]};
        s0.res.b_written = 1'b1;
      end
      OP_SUB: begin
        s0.res.result_b = b - a; s0.res.overflow_out = (b < a) ? 16'hffff : 16'd0;
        s0.res.b_written = 1'b1;
      end
      OP_MUL: begin
        s0.res.result_b = mul_u[15:0]; s0.res.overflow_out = mul_u[31:16];
        s0.res.b_written = 1'b1;
      end
      OP_MLI: begin
        s0.res.result_b = mul_s[15:0]; s0.res.overflow_out = mul_s[31:16];
        s0.res.b_written = 1'b1;
      end
      OP_DIV, OP_DVI, OP_MOD, OP_MDI: s0.res.b_written = 1'b1;
      OP_AND: begin s0.res.result_b = b & a; s0.res.b_written = 1'b1; end
      OP_BOR: begin s0.res.result_b = b | a; s0.res.b_written = 1'b1; end
      OP_XOR: begin s0.res.result_b = b ^ a; s0.res.b_written = 1'b1; end
      OP_SHR: begin
        s0.res.b_written = 1'b1;
        s0.res.result_b     = (a < 16'd32) ? shr_t[31:16] : 16'd0;
        s0.res.overflow_out = (a < 16'd32) ? shr_t[15:0] : 16'd0;
      end
      OP_ASR: begin
        s0.res.b_written = 1'b1;
        s0.res.result_b     = (a < 16'd32) ? 16'($signed(b) >>> asr_sh) : 16'd0;
        s0.res.overflow_out = (a <= 16'd16) ? asr_t[15:0] : 16'd0;
      end
      OP_SHL: begin
        s0.res.b_written = 1'b1;
        s0.res.result_b     = (a < 16'd32) ? shl_t[15:0] : 16'd0;
        s0.res.overflow_out = (a < 16'd32) ? shl_t[31:16] : 16'd0;
      end
      OP_IFB: s0.res.skip_next = ((a & b) == 16'd0);
      OP_IFC: s0.res.skip_next = ((a & b) != 16'd0);
      OP_IFE: s0.res.skip_next = (a != b);
      OP_IFN: s0.res.skip_next = (a == b);
      OP_IFG: s0.res.skip_next = !(b > a);
      OP_IFA: s0.res.skip_next = !($signed(b) > $signed(a));
      OP_IFL: s0.res.skip_next = !(b < a);
      OP_IFU: s0.res.skip_next = !($signed(b) < $signed(a));
      OP_ADX: begin
        s0.res.result_b = adx_t[15:0];
        s0.res.overflow_out = (adx_t[17:16] != 2'd0) ? 16'd1 : 16'd0;
        s0.res.b_written = 1'b1;
      end
      OP_SBX: begin
        s0.res.result_b = sbx_v[15:0];
        s0.res.overflow_out = sbx_v[17] ? 16'hffff :
                              (sbx_v[16] ? 16'd1 : 16'd0);
        s0.res.b_written = 1'b1;
      end
      OP_STI: begin
        s0.res.result_b = a; s0.res.b_written = 1'b1; s0.res.index_step = STEP_INC;
      end
      OP_STD: begin
        s0.res.result_b = a; s0.res.b_written = 1'b1; s0.res.index_step = STEP_DEC;
      end
      default: ;
    endcase
  end

  w16a_div u_div (
    .clk    (clk),
    .en     (adv),
    .num_in (num),
    .den_in (den),
    .quo_out(quo),
    .mod_out(md)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DivDepth; i++) vld_r[i] <= 1'b0;
      ov_r <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= head.valid;
      for (int i = 1; i < DivDepth; i++) vld_r[i] <= vld_r[i-1];
      ov_r <= vld_r[DivDepth-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pl_r[0] <= s0;
      for (int i = 1; i < DivDepth; i++) pl_r[i] <= pl_r[i-1];
      res_r <= res_nxt;
    end
  end

  assign quo_n = 32'(-quo);
  assign qhi   = quo[31:16];

  always_comb begin
    res_nxt = pl_r[DivDepth-1].res;
    case (pl_r[DivDepth-1].kind)
      DK_UDIV: begin
        res_nxt.result_b     = pl_r[DivDepth-1].dz ? 16'd0 : qhi;
        res_nxt.overflow_out = pl_r[DivDepth-1].dz ? 16'd0 : quo[15:0];
      end
      DK_SDIV: begin
        res_nxt.result_b     = pl_r[DivDepth-1].dz ? 16'd0 :
                               (pl_r[DivDepth-1].neg_q ? 16'(-qhi) : qhi);
        res_nxt.overflow_out = pl_r[DivDepth-1].dz ? 16'd0 :
                               (pl_r[DivDepth-1].neg_q ? quo_n[15:0] : quo[15:0]);
      end
      DK_UMOD: res_nxt.result_b = pl_r[DivDepth-1].dz ? 16'd0 : md;
      DK_SMOD: res_nxt.result_b = pl_r[DivDepth-1].dz ? 16'd0 :
                                  (pl_r[DivDepth-1].neg_r ? 16'(-md) : md);
      default: ;
    endcase
  end

  assign out_valid = ov_r;
  assign out_res   = res_r;

endmodule
